>>> rtl/ppd_pkg.sv
// ============================================================================
// ppd_pkg: shared constant for the persistence point distance core
// Default coordinate width used by the core and its channel interfaces.
// ============================================================================
`default_nettype none

package ppd_pkg;

  // Coordinate width in bits (signed fixed point)
  localparam int PPD_COORD_WIDTH = 32;

endpackage : ppd_pkg

`default_nettype wire

>>> rtl/ppd_if.sv
// ============================================================================
// ppd_if: valid/ready channels of the persistence point distance core
// ppd_pair_if carries one point pair per beat, ppd_dist_if one distance.
// ============================================================================
`default_nettype none

interface ppd_pair_if
  import ppd_pkg::*;
#(
  parameter int COORD_WIDTH = PPD_COORD_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;

  modport source (
    output valid, first_x, first_y, second_x, second_y,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_y, second_x, second_y,
    output ready
  );

endinterface : ppd_pair_if

interface ppd_dist_if
  import ppd_pkg::*;
#(
  parameter int COORD_WIDTH = PPD_COORD_WIDTH
) ();

  logic                 valid;
  logic                 ready;
  logic [COORD_WIDTH:0] distance;

  modport source (
    output valid, distance,
    input  ready
  );

  modport sink (
    input  valid, distance,
    output ready
  );

endinterface : ppd_dist_if

`default_nettype wire

>>> rtl/persistence_point_distance_core.sv
// ============================================================================
// persistence_point_distance_core: point distance with diagonal matching
// Returns min(Euclidean distance, via-diagonal cost) of two diagram points.
// ============================================================================
// The core takes one point pair per clock cycle and returns one distance per
// pair, in order. Most of the pipeline depth comes from the two digit-recurrence
// square roots, which resolve one result bit per pipeline stage and run side
// by side over COORD_WIDTH + 2 stages; the front end spends five stages on
// differences, magnitudes, split partial products and squares, and one stage
// rounds. A two-beat output buffer holds finished results: the core keeps
// taking pairs while one result waits, and pauses the whole pipeline only when
// both buffer entries are full. Coordinates are signed fixed point; the
// distance carries the same number of fraction bits and one more integer bit.
`default_nettype none

module persistence_point_distance_core
  import ppd_pkg::*;
#(
  parameter int COORD_WIDTH = PPD_COORD_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ppd_pair_if.sink      in_pt,
  ppd_dist_if.source    out_dist
);

  // Widths
  localparam int W   = COORD_WIDTH;
  localparam int OW  = W + 1;          // distance width
  localparam int TW  = W + 1;          // diagonal term sum width
  localparam int HM  = (W + 1) / 2;    // split point of a W-bit magnitude
  localparam int HT  = (TW + 1) / 2;   // split point of the term sum
  localparam int SQW = 2 * W;          // square of a magnitude
  localparam int TTW = 2 * TW;         // square of the term sum
  localparam int N   = W + 2;          // root bits (and root stages)
  localparam int RW  = 2 * N;          // radicand width

  // One square root lane: remaining radicand bits, partial remainder, root
  typedef struct packed {
    logic [RW-1:0] rad;
    logic [N:0]    rem;
    logic [N-1:0]  root;
  } root_lane_t;

  // Magnitude of a (W+1)-bit two's complement difference
  function automatic logic [W-1:0] abs_mag(input logic [W:0] v);
    logic [W:0] n;
    n = v[W] ? (~v + 1'b1) : v;
    return n[W-1:0];
  endfunction

  // One restoring square root step: brings in two radicand bits
  function automatic root_lane_t root_step(input root_lane_t cur);
    root_lane_t    nxt;
    logic [N+2:0]  acc;
    logic [N+2:0]  trial;
    acc   = {cur.rem, cur.rad[RW-1:RW-2]};
    trial = {1'b0, cur.root, 2'b01};
    nxt.rad = {cur.rad[RW-3:0], 2'b00};
    if (acc >= trial) begin
      acc      = acc - trial;
      nxt.rem  = acc[N:0];
      nxt.root = {cur.root[N-2:0], 1'b1};
    end else begin
      nxt.rem  = acc[N:0];
      nxt.root = {cur.root[N-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // Pipeline advance: stops only when both output entries are full
  logic [1:0] cnt_r;
  logic       en;
  assign en = (cnt_r != 2'd2);
  assign in_pt.ready = en;

  // Stage 1: coordinate differences
  logic       s1_valid_r;
  logic [W:0] s1_dx_r, s1_dy_r, s1_d1_r, s1_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= {in_pt.second_x[W-1], in_pt.second_x} - {in_pt.first_x[W-1], in_pt.first_x};
      s1_dy_r <= {in_pt.second_y[W-1], in_pt.second_y} - {in_pt.first_y[W-1], in_pt.first_y};
      s1_d1_r <= {in_pt.first_y[W-1], in_pt.first_y} - {in_pt.first_x[W-1], in_pt.first_x};
      s1_d2_r <= {in_pt.second_y[W-1], in_pt.second_y}
                 - {in_pt.second_x[W-1], in_pt.second_x};
    end
  end

  // Stage 2: magnitudes and diagonal term sum
  logic         s2_valid_r;
  logic [W-1:0] s2_ax_r, s2_ay_r;
  logic [TW-1:0] s2_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax_r <= abs_mag(s1_dx_r);
      s2_ay_r <= abs_mag(s1_dy_r);
      s2_t_r  <= {1'b0, abs_mag(s1_d1_r)} + {1'b0, abs_mag(s1_d2_r)};
    end
  end

  // Stage 3: partial products of the three squares (halves of each operand)
  logic                    s3_valid_r;
  logic [2*(W-HM)-1:0]     s3_xhh_r, s3_yhh_r;
  logic [W-1:0]            s3_xhl_r, s3_yhl_r;
  logic [2*HM-1:0]         s3_xll_r, s3_yll_r;
  logic [2*(TW-HT)-1:0]    s3_thh_r;
  logic [TW-1:0]           s3_thl_r;
  logic [2*HT-1:0]         s3_tll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_xhh_r <= s2_ax_r[W-1:HM] * s2_ax_r[W-1:HM];
      s3_xhl_r <= s2_ax_r[W-1:HM] * s2_ax_r[HM-1:0];
      s3_xll_r <= s2_ax_r[HM-1:0] * s2_ax_r[HM-1:0];
      s3_yhh_r <= s2_ay_r[W-1:HM] * s2_ay_r[W-1:HM];
      s3_yhl_r <= s2_ay_r[W-1:HM] * s2_ay_r[HM-1:0];
      s3_yll_r <= s2_ay_r[HM-1:0] * s2_ay_r[HM-1:0];
      s3_thh_r <= s2_t_r[TW-1:HT] * s2_t_r[TW-1:HT];
      s3_thl_r <= s2_t_r[TW-1:HT] * s2_t_r[HT-1:0];
      s3_tll_r <= s2_t_r[HT-1:0] * s2_t_r[HT-1:0];
    end
  end

  // Stage 4: assemble squares, hi^2 << 2h + 2*hi*lo << h + lo^2
  logic           s4_valid_r;
  logic [SQW-1:0] s4_sqx_r, s4_sqy_r;
  logic [TTW-1:0] s4_tt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sqx_r <= {s3_xhh_r, {(2*HM){1'b0}}}
                  + SQW'({s3_xhl_r, {(HM+1){1'b0}}})
                  + SQW'(s3_xll_r);
      s4_sqy_r <= {s3_yhh_r, {(2*HM){1'b0}}}
                  + SQW'({s3_yhl_r, {(HM+1){1'b0}}})
                  + SQW'(s3_yll_r);
      s4_tt_r  <= {s3_thh_r, {(2*HT){1'b0}}}
                  + TTW'({s3_thl_r, {(HT+1){1'b0}}})
                  + TTW'(s3_tll_r);
    end
  end

  // Stage 5 and root stages: lane index 0 holds the radicands
  logic       rt_valid_r [0:N];
  root_lane_t eu_r       [0:N];
  root_lane_t dg_r       [0:N];
  logic [SQW:0] sq_sum;

  assign sq_sum = {1'b0, s4_sqx_r} + {1'b0, s4_sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_valid_r[0] <= 1'b0;
    end else if (en) begin
      rt_valid_r[0] <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eu_r[0].rad  <= RW'(sq_sum);
      eu_r[0].rem  <= '0;
      eu_r[0].root <= '0;
      dg_r[0].rad  <= RW'({s4_tt_r, 1'b0});
      dg_r[0].rem  <= '0;
      dg_r[0].root <= '0;
    end
  end

  // Digit-recurrence square roots, one root bit per stage
  for (genvar k = 0; k < N; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_valid_r[k+1] <= 1'b0;
      end else if (en) begin
        rt_valid_r[k+1] <= rt_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        eu_r[k+1] <= root_step(eu_r[k]);
        dg_r[k+1] <= root_step(dg_r[k]);
      end
    end
  end

  // Rounding stage: Euclidean rounds up when remainder exceeds root,
  // diagonal halves the root of 2*T^2 with rounding
  logic          rd_valid_r;
  logic [OW-1:0] rd_eucl_r, rd_diag_r;
  logic [N-1:0]  eucl_full;
  logic [N:0]    diag_sum;

  assign eucl_full = eu_r[N].root + N'(eu_r[N].rem > {1'b0, eu_r[N].root});
  assign diag_sum  = {1'b0, dg_r[N].root} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (en) begin
      rd_valid_r <= rt_valid_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_eucl_r <= eucl_full[OW-1:0];
      rd_diag_r <= diag_sum[OW:1];
    end
  end

  // Output buffer: two beats, head drives the result channel
  logic [OW-1:0] min_dist;
  logic [OW-1:0] buf0_r, buf1_r;
  logic          push, pop;

  assign min_dist = (rd_eucl_r < rd_diag_r) ? rd_eucl_r : rd_diag_r;
  assign push = en && rd_valid_r;
  assign pop  = out_dist.valid && out_dist.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          buf0_r <= min_dist;
        end else begin
          buf1_r <= min_dist;
        end
      end
      2'b01: begin
        buf0_r <= buf1_r;
      end
      2'b11: begin
        buf0_r <= min_dist;
      end
      default: begin
        buf0_r <= buf0_r;
      end
    endcase
  end

  assign out_dist.valid    = (cnt_r != 2'd0);
  assign out_dist.distance = buf0_r;

endmodule : persistence_point_distance_core

`default_nettype wire
